>>> hw/rtl/rsem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
package rsem_pkg;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ROW_LIMIT = 1024;
  localparam int IDX_FRAME_WIDTH = 0;
  localparam int IDX_FRAME_HEIGHT = 1;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [9:0] out_row;
    logic [9:0] out_col;
  } pixel_out_t;

  // One queued job: the 3x3 window, the centre position and border data.
  typedef struct packed {
    logic         interior;
    logic         border;
    logic [215:0] win;       // nine 24-bit pixels, tl ml bl tc mc bc tr mr br
    logic [9:0]   irow;
    logic [9:0]   icol;
    logic [23:0]  bpix;
    logic [9:0]   brow;
    logic [9:0]   bcol;
  } job_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_ROOT, ST_EMIT} back_state_t;
endpackage

>>> hw/rtl/rsem_front.sv
// Front end: position counters, line stores, window and job formation.
`timescale 1ns / 1ps
module rsem_front #(
  parameter int MAX_WIDTH = rsem_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsem_pkg::pixel_in_t in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic                cfg_hi,
  input  logic [10:0]         cfg_data,
  output logic                job_valid,
  input  logic                job_full,
  output rsem_pkg::job_t      job
);
  localparam int COL_LIMIT = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int AW = $clog2(COL_LIMIT);

  logic [10:0] frame_width, frame_height;
  logic [9:0]  column_count, row_count;
  logic [23:0] upper_mem [COL_LIMIT];
  logic [23:0] middle_mem [COL_LIMIT];
  logic [23:0] win [6];
  // stage 1 holds the pixel while the line stores are read
  logic        s1_valid;
  logic [23:0] s1_pix;
  logic [9:0]  s1_row, s1_col;
  logic        s1_interior, s1_border;
  logic [23:0] top_rd, mid_rd;
  logic [10:0] w_eff, h_eff;
  logic [9:0]  c_next, r_next;
  logic        accept, cfg_take;

  always_comb begin
    w_eff = frame_width;
    if (w_eff == 11'd0) w_eff = 11'd1;
    if (w_eff > 11'(COL_LIMIT)) w_eff = 11'(COL_LIMIT);
    h_eff = frame_height;
    if (h_eff == 11'd0) h_eff = 11'd1;
    if (h_eff > 11'(rsem_pkg::ROW_LIMIT)) h_eff = 11'(rsem_pkg::ROW_LIMIT);
  end

  assign in_stall = job_full;
  assign cfg_ready = 1'b1;
  assign accept = in_valid && !in_stall;
  assign cfg_take = cfg_valid && !cfg_hi;

  always_comb begin
    c_next = column_count + 10'd1;
    r_next = row_count;
    if ({1'b0, c_next} >= w_eff || c_next == 10'd0) begin
      c_next = 10'd0;
      r_next = row_count + 10'd1;
      if ({1'b0, r_next} >= h_eff || r_next == 10'd0) r_next = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd1024;
      frame_height <= 11'd1024;
      column_count <= '0;
      row_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        column_count <= c_next;
        row_count <= r_next;
      end
      if (cfg_take) begin
        unique case (cfg_index)
          1'(rsem_pkg::IDX_FRAME_WIDTH): frame_width <= cfg_data;
          default: frame_height <= cfg_data;
        endcase
        column_count <= '0;
        row_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= in_data;
      s1_row <= row_count;
      s1_col <= column_count;
      s1_interior <= row_count >= 10'd2 && column_count >= 10'd2;
      s1_border <= row_count == 10'd0 || {1'b0, row_count} == h_eff - 11'd1 ||
                   column_count == 10'd0 || {1'b0, column_count} == w_eff - 11'd1;
      top_rd <= upper_mem[column_count[AW-1:0]];
      mid_rd <= middle_mem[column_count[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      upper_mem[s1_col[AW-1:0]] <= mid_rd;
      middle_mem[s1_col[AW-1:0]] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (s1_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_rd;
      win[4] <= mid_rd;
      win[5] <= s1_pix;
    end
  end

  assign job_valid = s1_valid && (s1_interior || s1_border);
  always_comb begin
    job.interior = s1_interior;
    job.border = s1_border;
    job.win = {win[0], win[1], win[2], win[3], win[4], win[5], top_rd, mid_rd, s1_pix};
    job.irow = s1_row - 10'd1;
    job.icol = s1_col - 10'd1;
    job.bpix = s1_pix;
    job.brow = s1_row;
    job.bcol = s1_col;
  end
endmodule

>>> hw/rtl/rsem_queue.sv
// Short job queue between front and back end.
`timescale 1ns / 1ps
module rsem_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  input  rsem_pkg::job_t wr_data,
  output logic           almost_full,
  output logic           rd_valid,
  input  logic           rd_take,
  output rsem_pkg::job_t rd_data
);
  localparam int DEPTH = 4;
  rsem_pkg::job_t mem [DEPTH];
  logic [1:0] wp, rp;
  logic [2:0] count;

  assign rd_valid = count != 3'd0;
  assign rd_data = mem[rp];
  // leave room for the item already in the read stage of the front end
  assign almost_full = count >= 3'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_valid) wp <= wp + 2'd1;
      if (rd_take && rd_valid) rp <= rp + 2'd1;
      count <= count + 3'(wr_valid) - 3'(rd_take && rd_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) mem[wp] <= wr_data;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 3'(DEPTH) |-> !wr_valid) else $error("job queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(DEPTH)) else $error("job queue count out of range");
  a_empty_no_take: assert property (@(posedge clk) disable iff (rst)
    count == 3'd0 && !wr_valid |=> count == 3'd0) else $error("queue count drift");
`endif
endmodule

>>> hw/rtl/rsem_back.sv
// Back end: Sobel sums, iterative rounded square root, result emission.
`timescale 1ns / 1ps
module rsem_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_take,
  input  rsem_pkg::job_t       job,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsem_pkg::pixel_out_t out_data
);
  rsem_pkg::back_state_t state, state_next;
  rsem_pkg::job_t        cur;
  logic                  did_interior;
  logic [16:0]           sq [3];
  logic [16:0]           rem [3];
  logic [8:0]            res [3];
  logic [3:0]            step;
  logic [7:0]            mag [3];
  logic [16:0]           rem_n [3];
  logic [8:0]            res_n [3];
  logic signed [11:0]    gx [3];
  logic signed [11:0]    gy [3];

  function automatic logic [7:0] px(input logic [215:0] w, input int p, input int sh);
    return w[(8-p)*24 + sh +: 8];
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      gx[ch] = $signed({4'd0, px(cur.win, 6, 16-8*ch)}) + 12'sd2 * $signed({4'd0, px(cur.win, 7, 16-8*ch)})
             + $signed({4'd0, px(cur.win, 8, 16-8*ch)}) - $signed({4'd0, px(cur.win, 0, 16-8*ch)})
             - 12'sd2 * $signed({4'd0, px(cur.win, 1, 16-8*ch)}) - $signed({4'd0, px(cur.win, 2, 16-8*ch)});
      gy[ch] = $signed({4'd0, px(cur.win, 2, 16-8*ch)}) + 12'sd2 * $signed({4'd0, px(cur.win, 5, 16-8*ch)})
             + $signed({4'd0, px(cur.win, 8, 16-8*ch)}) - $signed({4'd0, px(cur.win, 0, 16-8*ch)})
             - 12'sd2 * $signed({4'd0, px(cur.win, 3, 16-8*ch)}) - $signed({4'd0, px(cur.win, 6, 16-8*ch)});
    end
  end

  // one result bit per cycle: restoring root over 8 bits of a 16-bit sum
  always_comb begin
    logic [17:0] trial;
    for (int ch = 0; ch < 3; ch++) begin
      trial = {rem[ch][15:0], sq[ch][15:14]} - {7'd0, res[ch], 2'b01};
      if (!trial[17]) begin
        rem_n[ch] = trial[16:0];
        res_n[ch] = {res[ch][7:0], 1'b1};
      end else begin
        rem_n[ch] = {rem[ch][14:0], sq[ch][15:14]};
        res_n[ch] = {res[ch][7:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      // round up when remainder exceeds the root
      if ({8'd0, res[ch]} < rem[ch] || res[ch] > 9'd255 || sq[ch] == 17'h1ffff)
        mag[ch] = (res[ch] >= 9'd255 || sq[ch] == 17'h1ffff) ? 8'hff : 8'(res[ch] + 9'd1);
      else
        mag[ch] = (res[ch] > 9'd255) ? 8'hff : res[ch][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rsem_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    job_take = 1'b0;
    out_valid = 1'b0;
    out_data = '0;
    unique case (state)
      rsem_pkg::ST_IDLE: if (job_valid) begin
        job_take = 1'b1;
        state_next = job.interior ? rsem_pkg::ST_SUM : rsem_pkg::ST_EMIT;
      end
      rsem_pkg::ST_SUM: state_next = rsem_pkg::ST_ROOT;
      rsem_pkg::ST_ROOT: if (step == 4'd8) state_next = rsem_pkg::ST_EMIT;
      rsem_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (cur.interior && !did_interior)
          out_data = '{mag[0], mag[1], mag[2], cur.irow, cur.icol};
        else
          out_data = '{cur.bpix[23:16], cur.bpix[15:8], cur.bpix[7:0], cur.brow, cur.bcol};
        if (!out_stall) begin
          if (cur.interior && !did_interior && cur.border) state_next = rsem_pkg::ST_EMIT;
          else state_next = rsem_pkg::ST_IDLE;
        end
      end
      default: state_next = rsem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      did_interior <= 1'b0;
      step <= '0;
    end else begin
      if (job_take) did_interior <= 1'b0;
      else if (state == rsem_pkg::ST_EMIT && !out_stall) did_interior <= 1'b1;
      if (state == rsem_pkg::ST_SUM) step <= '0;
      else if (state == rsem_pkg::ST_ROOT) step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) cur <= job;
    if (state == rsem_pkg::ST_SUM) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic [23:0]        s;
        logic signed [23:0] ex, ey;
        ex = 24'(gx[ch]);
        ey = 24'(gy[ch]);
        s = $unsigned(ex * ex) + $unsigned(ey * ey);
        // above 255*255+255 saturate; mark with all ones
        sq[ch] <= (s > 24'd65280) ? 17'h1ffff : s[16:0];
        rem[ch] <= '0;
        res[ch] <= '0;
      end
    end else if (state == rsem_pkg::ST_ROOT && step != 4'd8) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem[ch] <= rem_n[ch];
        res[ch] <= res_n[ch];
        sq[ch] <= (sq[ch] == 17'h1ffff) ? sq[ch] : {sq[ch][14:0], 2'b00};
      end
    end
  end

`ifndef ASSERT_OFF
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    job_take |-> state == rsem_pkg::ST_IDLE) else $error("job taken while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step <= 4'd9) else $error("root step overrun");
`endif
endmodule

>>> hw/rtl/rgb_sobel_edge_magnitude.sv
// Top level of the streaming RGB Sobel edge magnitude block.
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | pixel_in_t (red, green, blue)
//  out     | out_valid/out_stall| pixel_out_t (magnitudes, row, col)
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A border-only pixel passes the back end's idle and emit states; an interior
// pixel adds the sum state and the eight-step square root shared by three channels.
// Line stores are single memories read in the cycle a pixel is accepted.
// Reset is synchronous; line-store contents are not cleared.
// in_stall rises while the job queue is nearly full.
`timescale 1ns / 1ps
module rgb_sobel_edge_magnitude #(
  parameter int MAX_WIDTH = rsem_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rsem_pkg::pixel_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsem_pkg::pixel_out_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data
);
  logic           f_valid, q_full, q_valid, q_take;
  rsem_pkg::job_t f_job, q_job;

  rsem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .cfg_valid, .cfg_ready,
    .cfg_index(cfg_index[0:0]), .cfg_hi(cfg_index[1]), .cfg_data,
    .job_valid(f_valid), .job_full(q_full), .job(f_job)
  );

  rsem_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_data(f_job), .almost_full(q_full),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_job)
  );

  rsem_back u_back (
    .clk, .rst, .job_valid(q_valid), .job_take(q_take), .job(q_job),
    .out_valid, .out_stall, .out_data
  );
endmodule

>>> bench/rgb_sobel_edge_magnitude_tb.sv
// Self-checking testbench for the RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
module rgb_sobel_edge_magnitude_tb;
  localparam int IDX_SPARE = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_PIXELS = 550;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  rsem_pkg::pixel_in_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  rsem_pkg::pixel_out_t out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [10:0]          cfg_data;

  // Predicted image state
  logic [23:0] upper_row_mem [rsem_pkg::MAX_WIDTH_DEF];
  logic [23:0] middle_row_mem [rsem_pkg::MAX_WIDTH_DEF];
  logic [23:0] win_cols [6];
  int unsigned col_pos, row_pos;
  int unsigned cfg_width, cfg_height;

  rsem_pkg::pixel_out_t expected_pixels [$];
  int         error_count;
  int         idle_pct, stall_pct;
  int         idle_cycles;
  int         sent_pixels;

  rgb_sobel_edge_magnitude u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int chan(logic [23:0] px, int sh);
    return int'((px >> sh) & 24'hFF);
  endfunction

  // Rounded square root of gx^2 + gy^2, clamped to 255
  function automatic logic [7:0] edge_mag(logic [23:0] l [3], logic [23:0] m [3],
                                          logic [23:0] r [3], int sh);
    int gx, gy, s, f;
    gx = (chan(r[0], sh) + 2 * chan(r[1], sh) + chan(r[2], sh))
       - (chan(l[0], sh) + 2 * chan(l[1], sh) + chan(l[2], sh));
    gy = (chan(l[2], sh) + 2 * chan(m[2], sh) + chan(r[2], sh))
       - (chan(l[0], sh) + 2 * chan(m[0], sh) + chan(r[0], sh));
    s = gx * gx + gy * gy;
    if (s > 255 * 255 + 255) return 8'd255;
    f = 0;
    while ((f + 1) * (f + 1) <= s) f++;
    if (s > f * f + f) f++;
    return (f > 255) ? 8'd255 : f[7:0];
  endfunction

  function automatic void sobel_predict(rsem_pkg::pixel_in_t p);
    int unsigned w, h, r, c;
    logic [23:0] cur, top, mid;
    logic [23:0] lc [3], mc [3], rc [3];
    rsem_pkg::pixel_out_t o;
    w = (cfg_width == 0) ? 1 : (cfg_width > rsem_pkg::MAX_WIDTH_DEF ?
        rsem_pkg::MAX_WIDTH_DEF : cfg_width);
    h = (cfg_height == 0) ? 1 : (cfg_height > rsem_pkg::ROW_LIMIT ?
        rsem_pkg::ROW_LIMIT : cfg_height);
    r = row_pos;
    c = col_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    cur = p;
    top = upper_row_mem[c];
    mid = middle_row_mem[c];
    if (r >= 2 && c >= 2) begin
      lc = '{win_cols[0], win_cols[1], win_cols[2]};
      mc = '{win_cols[3], win_cols[4], win_cols[5]};
      rc = '{top, mid, cur};
      o.out_red   = edge_mag(lc, mc, rc, 16);
      o.out_green = edge_mag(lc, mc, rc, 8);
      o.out_blue  = edge_mag(lc, mc, rc, 0);
      o.out_row   = 10'(r - 1);
      o.out_col   = 10'(c - 1);
      expected_pixels.push_back(o);
    end
    if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
      o.out_red   = p.in_red;
      o.out_green = p.in_green;
      o.out_blue  = p.in_blue;
      o.out_row   = 10'(r);
      o.out_col   = 10'(c);
      expected_pixels.push_back(o);
    end
    upper_row_mem[c] = mid;
    middle_row_mem[c] = cur;
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = cur;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  task automatic send_pixel(rsem_pkg::pixel_in_t p);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    sobel_predict(p);
    sent_pixels++;
  endtask

  task automatic send_random(int n);
    repeat (n) send_pixel(rsem_pkg::pixel_in_t'(24'($urandom)));
  endtask

  task automatic wait_drained();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Let the block go idle, then write one register
  task automatic write_reg(int idx, int value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data  <= 11'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == rsem_pkg::IDX_FRAME_WIDTH || idx == rsem_pkg::IDX_FRAME_HEIGHT) begin
      if (idx == rsem_pkg::IDX_FRAME_WIDTH) cfg_width = value;
      else cfg_height = value;
      col_pos = 0;
      row_pos = 0;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(int w, int h);
    write_reg(rsem_pkg::IDX_FRAME_WIDTH, w);
    write_reg(rsem_pkg::IDX_FRAME_HEIGHT, h);
  endtask

  task automatic test_reset_size();
    send_random(6);
  endtask

  task automatic test_tiny_frames();
    set_frame(1, 1);
    send_random(3);
    set_frame(2, 2);
    send_random(5);
    set_frame(0, 0);
    send_random(2);
  endtask

  task automatic test_saturation();
    rsem_pkg::pixel_in_t lo, hi;
    lo = '0;
    hi = '1;
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? hi : lo);
    set_frame(4, 3);
    for (int i = 0; i < 12; i++) send_pixel(((i + i / 4) % 2) ? hi : lo);
  endtask

  task automatic test_register_limits();
    set_frame(2047, 3);
    send_random(5);
    set_frame(3, 1024);
    send_random(12);
    write_reg(rsem_pkg::IDX_FRAME_HEIGHT, 2047);
    send_random(6);
    // spare index: no effect, frame continues
    write_reg(IDX_SPARE, 11'h5A5);
    send_random(6);
  endtask

  task automatic test_random_frames();
    int w, h, sel, phase;
    phase = 0;
    while (sent_pixels < RANDOM_PIXELS - 50) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      phase++;
      sel = $urandom_range(99);
      if (sel < 10) begin
        w = $urandom_range(1, 2);
        h = $urandom_range(1, 4);
      end else if (sel < 14) begin
        w = $urandom_range(40, 160);
        h = $urandom_range(3, 4);
      end else begin
        w = $urandom_range(3, 9);
        h = $urandom_range(3, 7);
      end
      set_frame(w, h);
      if (w * h > 100) send_random(w + 3);
      else if ($urandom_range(9) == 0) send_random($urandom_range(1, w * h));
      else send_random(w * h * $urandom_range(1, 2));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    sent_pixels = 0;
    idle_pct = 0;
    stall_pct = 0;
    col_pos = 0;
    row_pos = 0;
    cfg_width = rsem_pkg::MAX_WIDTH_DEF;
    cfg_height = rsem_pkg::ROW_LIMIT;
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    for (int i = 0; i < rsem_pkg::MAX_WIDTH_DEF; i++) begin
      upper_row_mem[i] = '0;
      middle_row_mem[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_size();
    test_tiny_frames();
    test_saturation();
    test_register_limits();
    test_random_frames();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    rsem_pkg::pixel_out_t exp_px;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output transfer row %0d col %0d", out_data.out_row,
               out_data.out_col);
        error_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_data.out_red !== exp_px.out_red) begin
          $error("out_red expected %0d actual %0d", exp_px.out_red, out_data.out_red);
          error_count++;
        end
        if (out_data.out_green !== exp_px.out_green) begin
          $error("out_green expected %0d actual %0d", exp_px.out_green,
                 out_data.out_green);
          error_count++;
        end
        if (out_data.out_blue !== exp_px.out_blue) begin
          $error("out_blue expected %0d actual %0d", exp_px.out_blue, out_data.out_blue);
          error_count++;
        end
        if (out_data.out_row !== exp_px.out_row) begin
          $error("out_row expected %0d actual %0d", exp_px.out_row, out_data.out_row);
          error_count++;
        end
        if (out_data.out_col !== exp_px.out_col) begin
          $error("out_col expected %0d actual %0d", exp_px.out_col, out_data.out_col);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule

>>> filelist.f
hw/rtl/rsem_pkg.sv
hw/rtl/rsem_front.sv
hw/rtl/rsem_queue.sv
hw/rtl/rsem_back.sv
hw/rtl/rgb_sobel_edge_magnitude.sv
bench/rgb_sobel_edge_magnitude_tb.sv
